[hw/rtl/pausable_scaled_timer_top_macros.svh]
// Assertion macros for the timer RTL.
`ifndef PAUSABLE_SCALED_TIMER_TOP_MACROS_SVH
`define PAUSABLE_SCALED_TIMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define PST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/pst_pkg.sv]
// Types and constants for the pausable scaled timer.
`timescale 1ns / 1ps

package pst_pkg;

	localparam int CMD_W       = 3;
	localparam int OPERAND_W   = 32;
	localparam int OUT_MS_W    = 48;
	localparam int RATE_W      = 16;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 48;

	localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UNPAUSE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FFWD    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REWIND  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd6;

	localparam logic [CFG_INDEX_W-1:0] REG_RATE   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET = 1'd1;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [OPERAND_W-1:0] operand_value;
	} cmd_t;

	typedef struct packed {
		logic [OUT_MS_W-1:0] elapsed_ms;
		logic [OUT_MS_W-1:0] step_ms;
		logic [OUT_MS_W-1:0] remaining_ms;
		logic                is_paused;
		logic                is_started;
	} res_t;

endpackage

[hw/rtl/pausable_scaled_timer_top.sv]
// Pausable, rate-scaled stopwatch driven by timestamp commands.
`timescale 1ns / 1ps
`include "pausable_scaled_timer_top_macros.svh"

// The timer takes one command item per clock while the result side does not stall and
// returns exactly one result item for each accepted command.
// The first stage registers the command; the second applies it to the timer state
// (stamp difference, scaling multiply by the rate register and a saturating add of
// 48 bits, all within that stage because the next command needs the updated state); the
// third forms the remaining countdown time and holds the result item until it is
// taken. The update path through the multiplier and the accumulator adder sets the
// clock period. The command channel's stall is combinational from the result
// channel's stall, so a full pipeline keeps taking a new item in every cycle in which
// a result item leaves. Configuration writes take effect on the next clock and must
// be made only while no command is in flight; a write of zero to the rate register
// keeps the previous rate.
module pausable_scaled_timer_top #(
	parameter int STAMP_WIDTH    = 32,
	parameter int COUNT_WIDTH    = 48,
	parameter int RATE_FRAC_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  pst_pkg::cmd_t                      cmd,
	output logic                               res_valid,
	input  logic                               res_stall,
	output pst_pkg::res_t                      res,
	input  logic                               cfg_we,
	input  logic [pst_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pst_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pst_pkg::*;

	// The full product of a stamp difference and the rate, then the product with the
	// fraction bits dropped, and a width that holds both that and the counter.
	localparam int PROD_W = STAMP_WIDTH + RATE_W;
	localparam int QUOT_W = PROD_W - RATE_FRAC_BITS;
	localparam int SCL_W  = (QUOT_W > COUNT_WIDTH) ? QUOT_W : COUNT_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};
	localparam logic [RATE_W-1:0]      RATE_RESET = RATE_W'(1) << RATE_FRAC_BITS;

	// Configuration registers.
	logic [RATE_W-1:0]      rate_q;
	logic [COUNT_WIDTH-1:0] target_q;

	// Timer state.
	logic                   paused_q;
	logic                   resume_pend_q;
	logic                   started_q;
	logic [STAMP_WIDTH-1:0] last_stamp_q;
	logic [COUNT_WIDTH-1:0] acc_q;
	logic [COUNT_WIDTH-1:0] last_step_q;

	// Pipeline registers.
	logic                   valid_s1;
	logic [CMD_W-1:0]       cmd_code_s1;
	logic [OPERAND_W-1:0]   operand_s1;
	logic                   valid_s2;
	logic [COUNT_WIDTH-1:0] elapsed_s2;
	logic [COUNT_WIDTH-1:0] step_s2;
	logic                   paused_s2;
	logic                   started_s2;
	logic                   res_valid_q;
	res_t                   res_q;

	// Flow control.
	logic out_ready;
	logic ready_s2;
	logic ready_s1;
	logic move_s1;
	logic move_s2;
	logic move_out;

	assign out_ready = !res_valid_q || !res_stall;
	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign move_s1   = cmd_valid && ready_s1;
	assign move_s2   = valid_s1 && ready_s2;
	assign move_out  = valid_s2 && out_ready;
	assign cmd_stall = !ready_s1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Scaled step of an update: stamp difference modulo the stamp width, times the
	// rate, fraction bits dropped, saturated at the counter maximum.
	logic [STAMP_WIDTH-1:0] stamp_s1;
	logic [STAMP_WIDTH-1:0] delta;
	logic [PROD_W-1:0]      product;
	logic [QUOT_W-1:0]      quot;
	logic [SCL_W-1:0]       quot_ext;
	logic [COUNT_WIDTH-1:0] step_new;
	logic [COUNT_WIDTH-1:0] operand_ext;
	logic [COUNT_WIDTH-1:0] addend;
	logic [COUNT_WIDTH:0]   sum;
	logic [COUNT_WIDTH-1:0] sum_sat;
	logic [COUNT_WIDTH-1:0] rewound;

	assign stamp_s1    = STAMP_WIDTH'(operand_s1);
	assign delta       = stamp_s1 - last_stamp_q;
	assign product     = PROD_W'(delta) * PROD_W'(rate_q);
	assign quot        = QUOT_W'(product >> RATE_FRAC_BITS);
	assign quot_ext    = SCL_W'(quot);
	assign step_new    = (quot_ext > SCL_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_WIDTH'(quot_ext);
	assign operand_ext = COUNT_WIDTH'(operand_s1);

	// One saturating adder serves both the update and the fast forward.
	assign addend  = (cmd_code_s1 == CMD_FFWD) ? operand_ext : step_new;
	assign sum     = {1'b0, acc_q} + {1'b0, addend};
	assign sum_sat = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
	assign rewound = (acc_q > operand_ext) ? (acc_q - operand_ext) : '0;

	logic                   paused_d;
	logic                   resume_pend_d;
	logic                   started_d;
	logic [STAMP_WIDTH-1:0] last_stamp_d;
	logic [COUNT_WIDTH-1:0] acc_d;
	logic [COUNT_WIDTH-1:0] last_step_d;

	always_comb begin
		paused_d      = paused_q;
		resume_pend_d = resume_pend_q;
		started_d     = started_q;
		last_stamp_d  = last_stamp_q;
		acc_d         = acc_q;
		last_step_d   = last_step_q;
		case (cmd_code_s1)
			CMD_UPDATE: begin
				// An update before the first start changes nothing.
				if (started_q) begin
					last_stamp_d = stamp_s1;
					if (paused_q) begin
						// While paused only the marker moves, unless an unpause waits.
						if (resume_pend_q) begin
							paused_d      = 1'b0;
							resume_pend_d = 1'b0;
						end
					end else begin
						last_step_d   = step_new;
						acc_d         = sum_sat;
						resume_pend_d = 1'b0;
					end
				end
			end
			CMD_START: begin
				acc_d         = '0;
				last_step_d   = '0;
				last_stamp_d  = stamp_s1;
				paused_d      = 1'b0;
				resume_pend_d = 1'b1;
				started_d     = 1'b1;
			end
			CMD_PAUSE: begin
				paused_d = 1'b1;
			end
			CMD_UNPAUSE: begin
				resume_pend_d = 1'b1;
			end
			CMD_FFWD: begin
				acc_d = sum_sat;
			end
			CMD_REWIND: begin
				acc_d = rewound;
			end
			CMD_CLEAR: begin
				acc_d = '0;
			end
			default: begin
				// The unused code leaves the state alone.
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= RATE_RESET;
			target_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATE: begin
					if (cfg_data[RATE_W-1:0] != '0) begin
						rate_q <= cfg_data[RATE_W-1:0];
					end
				end
				REG_TARGET: begin
					target_q <= COUNT_WIDTH'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// Control state and timer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			res_valid_q   <= 1'b0;
			paused_q      <= 1'b0;
			resume_pend_q <= 1'b1;
			started_q     <= 1'b0;
			last_stamp_q  <= '0;
			acc_q         <= '0;
			last_step_q   <= '0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= cmd_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				res_valid_q <= valid_s2;
			end
			if (move_s2) begin
				paused_q      <= paused_d;
				resume_pend_q <= resume_pend_d;
				started_q     <= started_d;
				last_stamp_q  <= last_stamp_d;
				acc_q         <= acc_d;
				last_step_q   <= last_step_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (move_s1) begin
			cmd_code_s1 <= cmd.command;
			operand_s1  <= cmd.operand_value;
		end
		if (move_s2) begin
			elapsed_s2 <= acc_d;
			step_s2    <= last_step_d;
			paused_s2  <= paused_d;
			started_s2 <= started_d;
		end
		if (move_out) begin
			res_q.elapsed_ms   <= OUT_MS_W'(elapsed_s2);
			res_q.step_ms      <= OUT_MS_W'(step_s2);
			res_q.remaining_ms <= (target_q > elapsed_s2) ?
				OUT_MS_W'(target_q - elapsed_s2) : '0;
			res_q.is_paused    <= paused_s2;
			res_q.is_started   <= started_s2;
		end
	end

	`PST_ASSERT_NEXT(a_started_sticks, clk, arst_n, started_q, started_q, "started flag fell")
	`PST_ASSERT_NEXT(a_early_update_idle, clk, arst_n, move_s2 && (cmd_code_s1 == CMD_UPDATE) && !started_q, $stable(acc_q) && $stable(last_stamp_q), "update before start changed state")
	`PST_ASSERT_NEXT(a_rewind_no_rise, clk, arst_n, move_s2 && (cmd_code_s1 == CMD_REWIND), acc_q <= $past(acc_q), "rewind raised the time")
	`PST_ASSERT_NEXT(a_start_clears, clk, arst_n, move_s2 && (cmd_code_s1 == CMD_START), (acc_q == '0) && (last_step_q == '0) && !paused_q && started_q, "start did not clear the timer")
	`PST_ASSERT_SAME(a_rate_nonzero, clk, arst_n, 1'b1, rate_q != '0, "rate register holds zero")

endmodule
